// File: hw/rtl/tis_pkg.sv
// ----------------------------------------------------------------------------
// Telnet IAC stripper package
// Parser states, result kinds, telnet command codes and the result record
// shared by the parser, the output stage and the top level.
// ----------------------------------------------------------------------------
package tis_pkg;

  // Telnet command bytes.
  localparam logic [7:0] TN_IAC    = 8'hFF;
  localparam logic [7:0] TN_SB     = 8'd250;
  localparam logic [7:0] TN_SE     = 8'd240;
  localparam logic [7:0] TN_CMD_LO = 8'd251;
  localparam logic [7:0] TN_CMD_HI = 8'd254;
  localparam logic [7:0] TN_DO     = 8'd253;

  // Reset value of the option register.
  localparam logic [7:0] OPTION_RESET = 8'd201;

  // Parser state.
  typedef enum logic [2:0] {
    ST_NORMAL = 3'd0,
    ST_IAC    = 3'd1,
    ST_CMD    = 3'd2,
    ST_SB     = 3'd3,
    ST_SB_IAC = 3'd4
  } parse_state_e;

  // Kind of a result transaction.
  typedef enum logic [2:0] {
    K_NONE    = 3'd0,
    K_DATA    = 3'd1,
    K_SBBYTE  = 3'd2,
    K_SBEND   = 3'd3,
    K_SBABORT = 3'd4,
    K_ENABLED = 3'd5
  } kind_e;

  // Fixed-width part of one result.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] byte_value;
    logic       chunk_end;
  } tis_item_t;

endpackage

// File: hw/rtl/tis_in_stage.sv
// ----------------------------------------------------------------------------
// Input stage
// Registers one received byte and its chunk-end flag, and accepts a new
// transaction when empty or when the held one moves on in the same cycle.
// ----------------------------------------------------------------------------
module tis_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_byte_i,
  input  logic       s_eoc_i,
  input  logic       take_i,     // held item is consumed this cycle
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       eoc_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       eoc_q;
  logic       load;

  // The stage is free when empty or when its item leaves this cycle.
  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= s_byte_i;
      eoc_q  <= s_eoc_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign eoc_o   = eoc_q;

endmodule

// File: hw/rtl/tis_parser.sv
// ----------------------------------------------------------------------------
// Telnet command parser
// Holds the parser state, the subnegotiation and chunk counters and the
// option register, and turns one byte into one result combinationally.
// ----------------------------------------------------------------------------
module tis_parser import tis_pkg::*; #(
  parameter int unsigned SB_CAPACITY = 1024,
  parameter int unsigned CHUNK_MAX   = 4096,
  localparam int unsigned SbW = $clog2(SB_CAPACITY),
  localparam int unsigned CW  = $clog2(CHUNK_MAX + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [7:0]     cfg_wdata_i,
  input  logic           step_i,      // consume the byte below this cycle
  input  logic [7:0]     rx_byte_i,
  input  logic           eoc_i,
  output tis_item_t      item_o,
  output logic [SbW-1:0] sb_length_o,
  output logic [CW-1:0]  kept_count_o
);

  localparam logic [SbW-1:0] SbMax    = SbW'(SB_CAPACITY - 1);
  localparam logic [CW-1:0]  ChunkTop = CW'(CHUNK_MAX);

  parse_state_e   state_q, state_d;
  logic           pend_do_q, pend_do_d;
  logic [SbW-1:0] sb_q, sb_d;
  logic           proto_q, proto_d;
  logic [CW-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [7:0]     option_q;
  logic           sb_room;
  kind_e          kind;
  logic [7:0]     bval;
  logic [SbW-1:0] slen;

  assign sb_room = sb_q < SbMax;

  // Next state and result for the current byte.
  always_comb begin
    state_d   = state_q;
    pend_do_d = pend_do_q;
    sb_d      = sb_q;
    proto_d   = proto_q;
    kind      = K_NONE;
    bval      = 8'd0;
    slen      = '0;
    unique case (state_q)
      ST_IAC: begin
        if (rx_byte_i == TN_IAC) begin
          kind    = K_DATA;
          bval    = TN_IAC;
          state_d = ST_NORMAL;
        end else if (rx_byte_i == TN_SB) begin
          sb_d    = '0;
          state_d = ST_SB;
        end else if (rx_byte_i >= TN_CMD_LO && rx_byte_i <= TN_CMD_HI) begin
          pend_do_d = (rx_byte_i == TN_DO);
          state_d   = ST_CMD;
        end else begin
          state_d = ST_NORMAL;
        end
      end
      ST_CMD: begin
        if (pend_do_q && rx_byte_i == option_q && !proto_q) begin
          proto_d = 1'b1;
          kind    = K_ENABLED;
        end
        state_d = ST_NORMAL;
      end
      ST_SB: begin
        if (rx_byte_i == TN_IAC) begin
          state_d = ST_SB_IAC;
        end else if (sb_room) begin
          sb_d = sb_q + SbW'(1);
          kind = K_SBBYTE;
          bval = rx_byte_i;
        end
      end
      ST_SB_IAC: begin
        if (rx_byte_i == TN_SE) begin
          kind    = K_SBEND;
          slen    = sb_q;
          sb_d    = '0;
          state_d = ST_NORMAL;
        end else if (rx_byte_i == TN_IAC) begin
          if (sb_room) begin
            sb_d = sb_q + SbW'(1);
            kind = K_SBBYTE;
            bval = TN_IAC;
          end
          state_d = ST_SB;
        end else begin
          kind    = K_SBABORT;
          sb_d    = '0;
          state_d = ST_NORMAL;
        end
      end
      default: begin
        if (rx_byte_i == TN_IAC) begin
          state_d = ST_IAC;
        end else begin
          kind    = K_DATA;
          bval    = rx_byte_i;
          state_d = ST_NORMAL;
        end
      end
    endcase
  end

  // Saturating count of data bytes in the chunk, reported and cleared at its end.
  always_comb begin
    cnt_inc = cnt_q;
    if (kind == K_DATA && cnt_q < ChunkTop) begin
      cnt_inc = cnt_q + CW'(1);
    end
    cnt_d        = eoc_i ? '0 : cnt_inc;
    kept_count_o = eoc_i ? cnt_inc : '0;
  end

  assign item_o.kind       = kind;
  assign item_o.byte_value = bval;
  assign item_o.chunk_end  = eoc_i;
  assign sb_length_o       = slen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_NORMAL;
      pend_do_q <= 1'b0;
      sb_q      <= '0;
      proto_q   <= 1'b0;
      cnt_q     <= '0;
    end else if (step_i) begin
      state_q   <= state_d;
      pend_do_q <= pend_do_d;
      sb_q      <= sb_d;
      proto_q   <= proto_d;
      cnt_q     <= cnt_d;
    end
  end

  // Option register; the user writes it only while the block is idle, unchecked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      option_q <= OPTION_RESET;
    end else if (cfg_we_i) begin
      option_q <= cfg_wdata_i;
    end
  end

endmodule

// File: hw/rtl/tis_out_stage.sv
// ----------------------------------------------------------------------------
// Output stage
// Result register with valid flag; it takes a new result whenever it is
// empty or its current result is taken in the same cycle.
// ----------------------------------------------------------------------------
module tis_out_stage import tis_pkg::*; #(
  parameter int unsigned SbW = 10,
  parameter int unsigned CW  = 13
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  output logic           free_o,
  input  tis_item_t      item_i,
  input  logic [SbW-1:0] sb_length_i,
  input  logic [CW-1:0]  kept_count_i,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output tis_item_t      item_o,
  output logic [SbW-1:0] sb_length_o,
  output logic [CW-1:0]  kept_count_o
);

  logic           valid_q, valid_d;
  tis_item_t      item_q;
  logic [SbW-1:0] slen_q;
  logic [CW-1:0]  kept_q;

  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
      slen_q <= sb_length_i;
      kept_q <= kept_count_i;
    end
  end

  assign m_valid_o    = valid_q;
  assign item_o       = item_q;
  assign sb_length_o  = slen_q;
  assign kept_count_o = kept_q;

endmodule

// File: hw/rtl/telnet_iac_stripper.sv
// ----------------------------------------------------------------------------
// Telnet IAC stripper
// Removes telnet command sequences from a received byte stream, passes data
// bytes, streams subnegotiation payload and reports chunk data counts.
//
//   Channel  Dir  Handshake                 Content
//   s_axis   in   tvalid/tready             tdata: rx_byte, tlast: end_of_chunk
//   m_axis   out  tvalid/tready             tdata: byte_value, sb_length,
//                                           kept_count; tuser: kind;
//                                           tlast: chunk_end
//   cfg      in   cfg_we_i (no handshake)   cfg_wdata_i: option_code
//
// One transaction in and one out per cycle while the output is not stalled;
// input register, combinational parser and result register lie in between.
// Reset (async, active low) sets the option to 201 and clears control state.
// A stalled output holds its result; the input register keeps taking
// transactions as long as the result register can move.
// ----------------------------------------------------------------------------
module telnet_iac_stripper import tis_pkg::*; #(
  parameter int unsigned SB_CAPACITY = 1024,
  parameter int unsigned CHUNK_MAX   = 4096,
  localparam int unsigned SbW = $clog2(SB_CAPACITY),
  localparam int unsigned CW  = $clog2(CHUNK_MAX + 1),
  localparam int unsigned DW  = ((8 + SbW + CW + 7) / 8) * 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i,     // option_code
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [7:0]    s_axis_tdata_i,  // [7:0] rx_byte
  input  logic          s_axis_tlast_i,  // end_of_chunk
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [DW-1:0] m_axis_tdata_o,  // byte_value, sb_length, kept_count, zero fill
  output logic [2:0]    m_axis_tuser_o,  // kind
  output logic          m_axis_tlast_o   // chunk_end
);

  logic           in_valid, in_eoc, out_free, adv;
  logic [7:0]     in_byte;
  tis_item_t      res, out_item;
  logic [SbW-1:0] res_slen, out_slen;
  logic [CW-1:0]  res_kept, out_kept;

  // An item moves on when the result register can take its result.
  assign adv = in_valid && out_free;

  tis_in_stage u_in (
    .clk_i,
    .rst_ni,
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_byte_i  (s_axis_tdata_i),
    .s_eoc_i   (s_axis_tlast_i),
    .take_i    (adv),
    .valid_o   (in_valid),
    .byte_o    (in_byte),
    .eoc_o     (in_eoc)
  );

  tis_parser #(
    .SB_CAPACITY (SB_CAPACITY),
    .CHUNK_MAX   (CHUNK_MAX)
  ) u_parser (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .step_i       (adv),
    .rx_byte_i    (in_byte),
    .eoc_i        (in_eoc),
    .item_o       (res),
    .sb_length_o  (res_slen),
    .kept_count_o (res_kept)
  );

  tis_out_stage #(
    .SbW (SbW),
    .CW  (CW)
  ) u_out (
    .clk_i,
    .rst_ni,
    .load_i       (adv),
    .free_o       (out_free),
    .item_i       (res),
    .sb_length_i  (res_slen),
    .kept_count_i (res_kept),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .item_o       (out_item),
    .sb_length_o  (out_slen),
    .kept_count_o (out_kept)
  );

  // Pack the result fields, first field in the lowest bits.
  assign m_axis_tdata_o = DW'({out_kept, out_slen, out_item.byte_value});
  assign m_axis_tuser_o = out_item.kind;
  assign m_axis_tlast_o = out_item.chunk_end;

endmodule

// File: hw/rtl/tis_checker.sv
// ----------------------------------------------------------------------------
// Telnet IAC stripper port checker
// Watches the output channel for held results and for fields that must be
// zero when their kind or chunk flag does not call for them.
// ----------------------------------------------------------------------------
module tis_props import tis_pkg::*; #(
  parameter int unsigned SB_CAPACITY = 1024,
  parameter int unsigned CHUNK_MAX   = 4096,
  localparam int unsigned SbW = $clog2(SB_CAPACITY),
  localparam int unsigned CW  = $clog2(CHUNK_MAX + 1),
  localparam int unsigned DW  = ((8 + SbW + CW + 7) / 8) * 8
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          m_axis_tvalid_o,
  input logic          m_axis_tready_i,
  input logic [DW-1:0] m_axis_tdata_o,
  input logic [2:0]    m_axis_tuser_o,
  input logic          m_axis_tlast_o
);

  logic [7:0]     obyte;
  logic [SbW-1:0] oslen;
  logic [CW-1:0]  okept;

  assign obyte = m_axis_tdata_o[7:0];
  assign oslen = m_axis_tdata_o[8 +: SbW];
  assign okept = m_axis_tdata_o[8 + SbW +: CW];

  // A stalled result transaction keeps its content.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // The byte field is only used by data and payload results.
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != K_DATA && m_axis_tuser_o != K_SBBYTE
      |-> obyte == 8'd0)
    else $error("byte value set on a result without a byte");

  // The length field is only used when a subnegotiation ends.
  a_slen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != K_SBEND |-> oslen == '0)
    else $error("subnegotiation length outside its end result");

  // The kept count shows only at a chunk end and never above its limit.
  a_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o || okept == '0)
      && okept <= CW'(CHUNK_MAX))
    else $error("kept count outside a chunk end or over its limit");

endmodule

bind telnet_iac_stripper tis_props #(
  .SB_CAPACITY (SB_CAPACITY),
  .CHUNK_MAX   (CHUNK_MAX)
) u_tis_props (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// File: dv/tis_checker.sv
// ----------------------------------------------------------------------------
// Telnet IAC stripper checker
// Watches the input, output and option channels of the stripper. Each input
// transaction is run through a local model of the telnet parser, and the
// model's result is queued. Each output transaction is compared field by
// field with the oldest queued result. The error count and the number of
// results still awaited are reported to the testbench top.
// ----------------------------------------------------------------------------
module tis_checker import tis_pkg::*; #(
  parameter int unsigned SB_CAPACITY = 1024,
  parameter int unsigned CHUNK_MAX   = 4096,
  localparam int unsigned SbW = $clog2(SB_CAPACITY),
  localparam int unsigned CW  = $clog2(CHUNK_MAX + 1),
  localparam int unsigned DW  = ((8 + SbW + CW + 7) / 8) * 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i,
  input  logic          s_axis_tvalid_i,
  input  logic          s_axis_tready_i,
  input  logic [7:0]    s_axis_tdata_i,  // [7:0] rx_byte
  input  logic          s_axis_tlast_i,  // end_of_chunk
  input  logic          m_axis_tvalid_i,
  input  logic          m_axis_tready_i,
  input  logic [DW-1:0] m_axis_tdata_i,  // byte_value, sb_length, kept_count, zero fill
  input  logic [2:0]    m_axis_tuser_i,  // kind
  input  logic          m_axis_tlast_i,  // chunk_end
  output int            error_count_o,
  output int            pending_o
);

  // One stripper result as the model sees it.
  typedef struct packed {
    logic [2:0]     kind;
    logic [7:0]     byte_value;
    logic [SbW-1:0] sb_length;
    logic           chunk_end;
    logic [CW-1:0]  kept_count;
  } strip_result_t;

  // Local copy of the parser state and the option register.
  parse_state_e  parser_state;
  logic [7:0]    cmd_byte;
  logic [7:0]    option_code;
  logic          enabled;
  int unsigned   sb_kept;
  int unsigned   chunk_data;

  strip_result_t stripped_q[$];
  int            errors;
  int            awaited;

  assign error_count_o = errors;
  assign pending_o     = awaited;

  // Parse one received byte and return the result it produces.
  function automatic strip_result_t strip_byte(logic [7:0] c, logic eoc);
    strip_result_t r;
    r = '0;
    r.kind = K_NONE;
    r.chunk_end = eoc;
    case (parser_state)
      ST_IAC: begin
        if (c == TN_IAC) begin
          r.kind = K_DATA;
          r.byte_value = TN_IAC;
          parser_state = ST_NORMAL;
        end else if (c == TN_SB) begin
          sb_kept = 0;
          parser_state = ST_SB;
        end else if (c >= TN_CMD_LO && c <= TN_CMD_HI) begin
          cmd_byte = c;
          parser_state = ST_CMD;
        end else begin
          parser_state = ST_NORMAL;
        end
      end
      ST_CMD: begin
        if (cmd_byte == TN_DO && c == option_code && !enabled) begin
          enabled = 1'b1;
          r.kind = K_ENABLED;
        end
        parser_state = ST_NORMAL;
      end
      ST_SB: begin
        if (c == TN_IAC) begin
          parser_state = ST_SB_IAC;
        end else if (sb_kept + 1 < SB_CAPACITY) begin
          // Payload past capacity is dropped without a result.
          sb_kept++;
          r.kind = K_SBBYTE;
          r.byte_value = c;
        end
      end
      ST_SB_IAC: begin
        if (c == TN_SE) begin
          r.kind = K_SBEND;
          r.sb_length = SbW'(sb_kept);
          sb_kept = 0;
          parser_state = ST_NORMAL;
        end else if (c == TN_IAC) begin
          if (sb_kept + 1 < SB_CAPACITY) begin
            sb_kept++;
            r.kind = K_SBBYTE;
            r.byte_value = TN_IAC;
          end
          parser_state = ST_SB;
        end else begin
          r.kind = K_SBABORT;
          sb_kept = 0;
          parser_state = ST_NORMAL;
        end
      end
      default: begin
        if (c == TN_IAC) begin
          parser_state = ST_IAC;
        end else begin
          r.kind = K_DATA;
          r.byte_value = c;
          parser_state = ST_NORMAL;
        end
      end
    endcase

    // The chunk count saturates and is reported and cleared at chunk end.
    if (r.kind == K_DATA && chunk_data < CHUNK_MAX) chunk_data++;
    if (eoc) begin
      r.kept_count = CW'(chunk_data);
      chunk_data = 0;
    end
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
      errors++;
    end
  endfunction

  // Track the option register, predict on input and compare on output.
  always @(posedge clk_i or negedge rst_ni) begin
    strip_result_t want;
    if (!rst_ni) begin
      parser_state = ST_NORMAL;
      cmd_byte     = '0;
      option_code  = OPTION_RESET;
      enabled      = 1'b0;
      sb_kept      = 0;
      chunk_data   = 0;
      stripped_q.delete();
      errors       = 0;
      awaited      = 0;
    end else begin
      if (cfg_we_i) option_code = cfg_wdata_i;

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (stripped_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d byte %0d",
                   $time, m_axis_tuser_i, m_axis_tdata_i[7:0]);
          errors++;
        end else begin
          want = stripped_q.pop_front();
          check_field("kind", want.kind, m_axis_tuser_i);
          check_field("byte_value", want.byte_value, m_axis_tdata_i[7:0]);
          check_field("sb_length", want.sb_length, m_axis_tdata_i[8 +: SbW]);
          check_field("chunk_end", want.chunk_end, m_axis_tlast_i);
          check_field("kept_count", want.kept_count, m_axis_tdata_i[8 + SbW +: CW]);
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_i)
        stripped_q.push_back(strip_byte(s_axis_tdata_i, s_axis_tlast_i));

      awaited = stripped_q.size();
    end
  end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Telnet IAC stripper testbench
// Drives received bytes into the stripper: a short directed sequence over
// data, escaped IAC, option commands, subnegotiation end and abort, then
// randomized telnet traffic across several option settings, including a
// subnegotiation past capacity. Both channels idle in random bursts; a
// checker module predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import tis_pkg::*;

  localparam int unsigned SB_CAPACITY = 1024;
  localparam int unsigned CHUNK_MAX   = 4096;
  localparam int unsigned SbW = $clog2(SB_CAPACITY);
  localparam int unsigned CW  = $clog2(CHUNK_MAX + 1);
  localparam int unsigned DW  = ((8 + SbW + CW + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  logic [7:0]    cfg_wdata = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [7:0]    s_tdata = '0;
  logic          s_tlast = 1'b0;
  logic          m_tvalid;
  logic          m_tready = 1'b1;
  logic [DW-1:0] m_tdata;
  logic [2:0]    m_tuser;
  logic          m_tlast;

  int            errors;
  int            pending;
  int unsigned   cycles = 0;
  int unsigned   bytes_sent = 0;
  logic          calm = 1'b0;
  logic [7:0]    option_now = OPTION_RESET;

  always #2 clk = ~clk;

  telnet_iac_stripper #(
    .SB_CAPACITY(SB_CAPACITY),
    .CHUNK_MAX  (CHUNK_MAX)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  tis_checker #(
    .SB_CAPACITY(SB_CAPACITY),
    .CHUNK_MAX  (CHUNK_MAX)
  ) checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_i(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_i(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_i (m_tdata),
    .m_axis_tuser_i (m_tuser),
    .m_axis_tlast_i (m_tlast),
    .error_count_o  (errors),
    .pending_o      (pending)
  );

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Receiver back-pressure in random bursts, none once the run is calm.
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 11) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // Send one byte; entered and left just after a falling edge.
  task automatic push_byte(logic [7:0] b, logic last);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic chunk_mark();
    return $urandom_range(0, 15) == 0;
  endfunction

  // Stop sending until every predicted result has come out.
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic set_option(logic [7:0] v);
    hold_until_drained();
    repeat (3) @(negedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    option_now = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Bring the parser back to plain data from any state.
  task automatic resync();
    push_byte(TN_IAC, 1'b0);
    push_byte(TN_SE, 1'b0);
    push_byte(TN_IAC, 1'b0);
    push_byte(TN_SE, 1'b0);
  endtask

  // One random piece of telnet traffic, mostly well formed.
  task automatic send_sequence();
    int unsigned pick;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      b = 8'($urandom_range(0, 254));
      push_byte(b, chunk_mark());
    end else if (pick < 48) begin
      push_byte(TN_IAC, chunk_mark());
      push_byte(TN_IAC, chunk_mark());
    end else if (pick < 62) begin
      push_byte(TN_IAC, chunk_mark());
      push_byte(8'(TN_CMD_LO + $urandom_range(0, 3)), chunk_mark());
      b = $urandom_range(0, 1) ? option_now : 8'($urandom);
      push_byte(b, chunk_mark());
    end else if (pick < 82) begin
      push_byte(TN_IAC, chunk_mark());
      push_byte(TN_SB, chunk_mark());
      repeat ($urandom_range(0, 8)) begin
        b = 8'($urandom);
        push_byte(b, chunk_mark());
        if (b == TN_IAC) push_byte(TN_IAC, chunk_mark());
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        push_byte(TN_IAC, chunk_mark());
        push_byte(TN_SE, chunk_mark());
      end else if (pick < 9) begin
        // Abort with any byte other than SE or IAC.
        b = 8'($urandom);
        if (b == TN_SE || b == TN_IAC) b = TN_SB;
        push_byte(TN_IAC, chunk_mark());
        push_byte(b, chunk_mark());
      end
      // Otherwise the subnegotiation stays open and swallows what follows.
    end else if (pick < 90) begin
      push_byte(TN_IAC, chunk_mark());
      push_byte(8'($urandom_range(0, 249)), chunk_mark());
    end else begin
      push_byte(8'($urandom), chunk_mark());
    end
  endtask

  task automatic send_mix(int unsigned count);
    int unsigned stop;
    stop = bytes_sent + count;
    while (bytes_sent < stop) send_sequence();
  endtask

  // Main stimulus and verdict.
  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: plain data, escaped IAC, commands, subnegotiation end and abort.
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFE, 1'b1);
    push_byte(TN_IAC, 1'b0);
    push_byte(TN_IAC, 1'b0);
    push_byte(TN_IAC, 1'b0);
    push_byte(8'd241, 1'b0);
    push_byte(TN_IAC, 1'b0);
    push_byte(TN_CMD_LO, 1'b0);
    push_byte(OPTION_RESET, 1'b0);
    push_byte(TN_IAC, 1'b0);
    push_byte(TN_DO, 1'b0);
    push_byte(8'd200, 1'b0);
    push_byte(TN_IAC, 1'b0);
    push_byte(TN_SB, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(TN_IAC, 1'b0);
    push_byte(TN_IAC, 1'b0);
    push_byte(TN_IAC, 1'b0);
    push_byte(TN_SE, 1'b1);
    // IAC at a chunk end carries into the next chunk.
    push_byte(TN_IAC, 1'b1);
    push_byte(TN_SB, 1'b0);
    push_byte(TN_IAC, 1'b0);
    push_byte(8'h10, 1'b0);

    // Lowest option; the first matching DO enables the protocol.
    set_option(8'd0);
    send_mix(250);
    hold_until_drained();
    send_mix(150);

    // Highest option, and a subnegotiation past capacity.
    set_option(8'd255);
    send_mix(150);
    resync();
    push_byte(TN_IAC, 1'b0);
    push_byte(TN_SB, 1'b0);
    repeat (SB_CAPACITY + 6) push_byte(8'($urandom_range(0, 254)), 1'b0);
    push_byte(TN_IAC, 1'b0);
    push_byte(TN_SE, 1'b0);
    send_mix(100);

    // Random option.
    set_option(8'($urandom_range(1, 254)));
    resync();
    send_mix(150);

    // Last part at full rate on both sides.
    calm = 1'b1;
    send_mix(150);

    hold_until_drained();
    repeat (10) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
